### rtl/core/crcbe_pkg.sv
// ----------------------------------------------------------------------------
// crcbe_pkg
// Shared types, constants and byte-wide CRC update functions for the CRC
// byte engine.
// ----------------------------------------------------------------------------
package crcbe_pkg;

   // checksum kinds held in the configuration register
   typedef enum logic [1:0] {
      KIND_CRC32  = 2'd0,
      KIND_CRC64  = 2'd1,
      KIND_HDR32  = 2'd2,
      KIND_RSVD   = 2'd3
   } crc_kind_type;

   localparam int unsigned CRC_W   = 64;
   localparam int unsigned HALF_W  = 32;
   localparam int unsigned POS_W   = 6;

   localparam logic [31:0]      POLY32    = 32'hedb8_8320;
   localparam logic [63:0]      POLY64    = 64'h42f0_e1eb_a9ea_3693;
   localparam logic [31:0]      ONES32    = 32'hffff_ffff;
   localparam logic [POS_W-1:0] HOLE_FIRST = 6'd52;
   localparam logic [POS_W-1:0] HOLE_END   = 6'd56;
   // nominal header length in bytes; the masking does not depend on it
   localparam int unsigned      HDR_STREAM_LEN = 512;

   // result buffer geometry
   localparam int unsigned RSP_DEPTH = 3;
   localparam int unsigned RSP_PTR_W = 2;
   localparam int unsigned RSP_CNT_W = 2;

   // running checksum state
   typedef struct packed {
      logic [CRC_W-1:0] crc;
      logic [POS_W-1:0] pos;
   } crc_state_type;

   // start state of a message for a given kind
   function automatic crc_state_type start_state(input crc_kind_type kind);
      crc_state_type s;
      s.crc = (kind == KIND_CRC64) ? '0 : {{HALF_W{1'b0}}, ONES32};
      s.pos = '0;
      return s;
   endfunction

   // reflected crc32, one byte, lsb first
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  d);
      logic [31:0] c;
      c = crc_in ^ {24'd0, d};
      for (int b = 0; b < 8; b++) begin
         c = (c >> 1) ^ (c[0] ? POLY32 : 32'd0);
      end
      return c;
   endfunction

   // crc64 ecma-182, one byte, msb first
   function automatic logic [63:0] crc64_byte(input logic [63:0] crc_in,
                                              input logic [7:0]  d);
      logic [63:0] c;
      c = crc_in ^ {d, 56'd0};
      for (int b = 0; b < 8; b++) begin
         c = {c[62:0], 1'b0} ^ (c[63] ? POLY64 : 64'd0);
      end
      return c;
   endfunction

endpackage

### rtl/core/crcbe_if.sv
// ----------------------------------------------------------------------------
// crcbe_req_if / crcbe_rsp_if
// Valid/ready channels carrying message bytes in and checksums out.
// ----------------------------------------------------------------------------
interface crcbe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crcbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] crc_value;

   modport source (output valid, output crc_value, input ready);
   modport sink   (input valid, input crc_value, output ready);
endinterface

### rtl/core/crc32_crc64_byte_engine_unit.sv
// ----------------------------------------------------------------------------
// crc32_crc64_byte_engine_unit
// Running CRC-32 / CRC-64 ECMA-182 / header CRC-32 over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one message byte per item plus a last marker. rsp_if
//   returns one 64-bit checksum per message, on the item marked last; the
//   upper 32 bits are zero in the crc32 kinds. csr_write_enable and
//   csr_write_data select the kind (0 crc32, 1 crc64, 2 header crc32 with
//   bytes 52 to 55 taken as zero, 3 same as 0); a write drops any message
//   in progress and restarts the checksum. Write only while idle.
// Timing:
//   an item is registered on acceptance and folded into the checksum at
//   the next edge, where a last item's result enters the buffer; rsp_if
//   presents it once it is in the buffer. One item per cycle is sustained
//   while req_if.ready stays high; the byte update (eight unrolled bit
//   steps) sits between the input register and the state.
// Reset and stall:
//   reset selects kind 0 and the crc32 start state. Results wait in a
//   three-entry buffer; req_if.ready drops when the buffered results plus
//   any item in the input register reach the buffer depth.
// ----------------------------------------------------------------------------
module crc32_crc64_byte_engine_unit (
   input  logic        clock,
   input  logic        reset,
   crcbe_req_if.sink   req_if,
   crcbe_rsp_if.source rsp_if,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data
);

   crcbe_pkg::crc_kind_type         kind_ff, kind_in;
   crcbe_pkg::crc_state_type        state_ff, state_in;
   crcbe_pkg::crc_state_type        state_nxt;
   logic                            s1_valid_ff;
   logic [7:0]                      s1_byte_ff;
   logic                            s1_last_ff;
   logic [63:0]                     crc_value;
   logic [crcbe_pkg::RSP_CNT_W-1:0] level;
   logic [crcbe_pkg::RSP_CNT_W:0]   committed;
   logic                            accept;
   logic                            push;

   // room check counts the item already in the input register
   assign committed    = {1'b0, level} + {{crcbe_pkg::RSP_CNT_W{1'b0}}, s1_valid_ff};
   assign req_if.ready = (committed < (crcbe_pkg::RSP_CNT_W + 1)'(crcbe_pkg::RSP_DEPTH));
   assign accept       = req_if.valid && req_if.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_if.data_byte;
         s1_last_ff <= req_if.last_byte;
      end
   end

   // byte update
   crcbe_step u_step (
      .kind      (kind_ff),
      .state_cur (state_ff),
      .data_byte (s1_byte_ff),
      .last_byte (s1_last_ff),
      .state_nxt (state_nxt),
      .crc_value (crc_value)
   );

   // kind register and checksum state; a kind write restarts the message
   always_comb begin
      kind_in  = kind_ff;
      state_in = state_ff;
      if (csr_write_enable) begin
         kind_in  = crcbe_pkg::crc_kind_type'(csr_write_data);
         state_in = crcbe_pkg::start_state(kind_in);
      end else if (s1_valid_ff) begin
         state_in = state_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= crcbe_pkg::KIND_CRC32;
         state_ff <= crcbe_pkg::start_state(crcbe_pkg::KIND_CRC32);
      end else begin
         kind_ff  <= kind_in;
         state_ff <= state_in;
      end
   end

   // result buffer
   assign push = s1_valid_ff && s1_last_ff;

   crcbe_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (crc_value),
      .level     (level),
      .rsp_if    (rsp_if)
   );

   // position saturates at the end of the masked field
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.pos <= crcbe_pkg::HOLE_END)
      else $error("byte position out of range");

   // a finished message returns the running state to the start state
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (push && !csr_write_enable) |=>
         (state_ff == crcbe_pkg::start_state(kind_ff)))
      else $error("checksum not restarted after last item");

   // the crc32 kinds never carry upper bits in the running state
   a_crc32_upper_zero: assert property (@(posedge clock) disable iff (reset)
      (kind_ff != crcbe_pkg::KIND_CRC64) |-> (state_ff.crc[63:32] == 32'd0))
      else $error("upper checksum bits set in crc32 kind");

   // nothing is accepted while results could not be stored
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      accept |-> (committed < (crcbe_pkg::RSP_CNT_W + 1)'(crcbe_pkg::RSP_DEPTH)))
      else $error("item accepted without result room");

endmodule

### rtl/core/crcbe_step.sv
// ----------------------------------------------------------------------------
// crcbe_step
// Combinational byte update: advances the running checksum and position by
// one byte and forms the finished checksum for a last byte.
// ----------------------------------------------------------------------------
module crcbe_step (
   input  crcbe_pkg::crc_kind_type  kind,
   input  crcbe_pkg::crc_state_type state_cur,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   output crcbe_pkg::crc_state_type state_nxt,
   output logic [63:0]              crc_value
);

   logic                           wide;
   logic                           in_hole;
   logic [7:0]                     eff_byte;
   logic [31:0]                    crc32_new;
   logic [63:0]                    crc64_new;
   logic [63:0]                    crc_new;
   logic [crcbe_pkg::POS_W-1:0]    pos_new;

   // header mode zeroes the reserved field bytes
   assign wide    = (kind == crcbe_pkg::KIND_CRC64);
   assign in_hole = (kind == crcbe_pkg::KIND_HDR32) &&
                    (state_cur.pos >= crcbe_pkg::HOLE_FIRST) &&
                    (state_cur.pos <  crcbe_pkg::HOLE_END);
   assign eff_byte = in_hole ? 8'd0 : data_byte;

   // one byte through both polynomials
   assign crc32_new = crcbe_pkg::crc32_byte(state_cur.crc[31:0], eff_byte);
   assign crc64_new = crcbe_pkg::crc64_byte(state_cur.crc, data_byte);
   assign crc_new   = wide ? crc64_new : {32'd0, crc32_new};

   // position saturates once past the masked field
   assign pos_new = (state_cur.pos < crcbe_pkg::HOLE_END) ?
                    state_cur.pos + 6'd1 : state_cur.pos;

   // finished value, and restart on a last byte
   assign crc_value = wide ? crc64_new : {32'd0, ~crc32_new};

   always_comb begin
      if (last_byte) begin
         state_nxt = crcbe_pkg::start_state(kind);
      end else begin
         state_nxt.crc = crc_new;
         state_nxt.pos = pos_new;
      end
   end

endmodule

### rtl/core/crcbe_rsp_fifo.sv
// ----------------------------------------------------------------------------
// crcbe_rsp_fifo
// Small result buffer between the checksum stage and the output channel.
// ----------------------------------------------------------------------------
module crcbe_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic [63:0]                       push_data,
   output logic [crcbe_pkg::RSP_CNT_W-1:0]   level,
   crcbe_rsp_if.source                       rsp_if
);

   localparam logic [crcbe_pkg::RSP_PTR_W-1:0] LAST_SLOT =
      crcbe_pkg::RSP_PTR_W'(crcbe_pkg::RSP_DEPTH - 1);
   localparam logic [crcbe_pkg::RSP_CNT_W-1:0] FULL_CNT =
      crcbe_pkg::RSP_CNT_W'(crcbe_pkg::RSP_DEPTH);

   logic [63:0]                     mem_ff [crcbe_pkg::RSP_DEPTH];
   logic [crcbe_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [crcbe_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [crcbe_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic                            pop;

   assign pop            = rsp_if.valid && rsp_if.ready;
   assign rsp_if.valid   = (count_ff != '0);
   assign rsp_if.crc_value = mem_ff[rd_ptr_ff];
   assign level          = count_ff;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // no write into a full buffer
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == FULL_CNT) |-> (!push || pop))
      else $error("result buffer overflow");

   // level never passes depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("result buffer level out of range");

endmodule
